[rtl/rila_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rila_pkg
// Shared types and constants for the randomized identifier allocator with
// least-recently-allocated eviction.
// ----------------------------------------------------------------------------
package rila_pkg;

  // Pool size and eviction batch
  localparam int NUM_IDS     = 1024;
  localparam int EVICT_COUNT = 256;

  localparam int ID_W   = $clog2(NUM_IDS);
  localparam int LINK_W = ID_W + 1;
  localparam int RND_W  = 16;
  localparam int ROW_W  = 1 + 2 * LINK_W;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_IDS);

  // Eviction frees the oldest entries in two runs: the last
  // NUM_IDS % EVICT_COUNT entries first, then the run just before them.
  localparam int EVICT_SPAN     = (EVICT_COUNT < NUM_IDS) ? EVICT_COUNT : NUM_IDS;
  localparam int EVICT_TAIL_CNT = NUM_IDS % EVICT_COUNT;
  localparam int EVICT_BODY_CNT = EVICT_SPAN - EVICT_TAIL_CNT;

  // Request codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  target_id;
    logic [15:0] random_value;
  } req_t;

  typedef struct packed {
    logic [9:0] granted_id;
    logic       is_allocated;
    logic       status;
    logic       evicted;
  } rsp_t;

  // One row of the link memory per identifier
  typedef struct packed {
    logic              used;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
  } link_row_t;

  localparam link_row_t NULL_ROW = '{used: 1'b0, nxt: NULL_LINK, prv: NULL_LINK};

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_CHK,
    ST_A_MOD,
    ST_A_RDL,
    ST_A_WRF,
    ST_A_WRH,
    ST_A_WRI,
    ST_F_CHK,
    ST_L_CHK,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_E_SEG,
    ST_E_WRD,
    ST_E_WGET,
    ST_E_FRD,
    ST_E_FGET,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/rila_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rila_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rila_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/rila_mod.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rila_mod
// Bit-serial restoring remainder unit: random value modulo the free count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rila_mod (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rila_pkg::RND_W-1:0]  dividend,
  input  wire logic [rila_pkg::LINK_W-1:0] divisor,
  output logic                            done,
  output logic      [rila_pkg::ID_W-1:0]   rem
);
  import rila_pkg::*;

  localparam int CNT_W = $clog2(RND_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RND_W-1:0]  dvd_r, dvd_nxt;
  logic [LINK_W-1:0] div_r, div_nxt;
  logic [LINK_W-1:0] rem_r, rem_nxt;
  logic [LINK_W:0]   trial;

  // One shift-and-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[RND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(RND_W);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = LINK_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = LINK_W'(trial);
      end
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[ID_W-1:0];

endmodule
`default_nettype wire

[rtl/random_id_allocator_lru_evict.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// random_id_allocator_lru_evict
// Random identifier allocator with a recency list and oldest-first eviction.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; a finished result sits in an output
// register so the next request is taken while it waits. The free array and a
// per-identifier link row (in-use bit, next, prev) live in two RAMs with a
// registered read, so every step is a read followed by a write. An allocate
// is dominated by the bit-serial modulo of the random value by the free
// count. An allocate that finds the pool empty first evicts: it walks back
// from the tail and then releases the oldest EVICT_COUNT entries. After
// reset a clearing pass over all NUM_IDS entries initializes both RAMs; no
// request is taken until it finishes.
// ----------------------------------------------------------------------------
module random_id_allocator_lru_evict (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rila_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rila_pkg::rsp_t      out_data
);
  import rila_pkg::*;

  state_t            st_r, st_nxt;
  req_t              req_r, req_nxt;
  rsp_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_data_r, out_data_nxt;
  logic [LINK_W-1:0] fc_r, fc_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] tail_r, tail_nxt;
  logic [LINK_W-1:0] x_r, x_nxt;
  logic [LINK_W-1:0] nx_r, nx_nxt;
  logic [LINK_W-1:0] pv_r, pv_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] cnt_r, cnt_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;
  logic [ID_W-1:0]   slot_r, slot_nxt;
  logic [ID_W-1:0]   init_r, init_nxt;
  logic              ev_r, ev_nxt;
  logic              phase_r, phase_nxt;

  // RAM ports
  logic              fr_we;
  logic [ID_W-1:0]   fr_waddr, fr_raddr, fr_wdata, fr_rdata;
  logic              lk_we;
  logic [ID_W-1:0]   lk_waddr, lk_raddr;
  link_row_t         lk_wdata, rd;
  logic [ROW_W-1:0]  lk_rdata;

  logic              mod_start, mod_done;
  logic [ID_W-1:0]   mod_rem;
  logic              tid_ok;

  rila_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  rila_ram #(.WIDTH(ROW_W), .DEPTH(NUM_IDS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  rila_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (req_r.random_value),
    .divisor  (fc_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign rd     = link_row_t'(lk_rdata);
  assign tid_ok = ({1'b0, req_r.target_id} < LINK_W'(NUM_IDS));

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: next state, RAM accesses, register updates
  always_comb begin
    st_nxt        = st_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    fc_nxt        = fc_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    x_nxt         = x_r;
    nx_nxt        = nx_r;
    pv_nxt        = pv_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    slot_nxt      = slot_r;
    init_nxt      = init_r;
    ev_nxt        = ev_r;
    phase_nxt     = phase_r;
    fr_we         = 1'b0;
    fr_waddr      = slot_r;
    fr_wdata      = fr_rdata;
    fr_raddr      = mod_rem;
    lk_we         = 1'b0;
    lk_waddr      = x_r[ID_W-1:0];
    lk_wdata      = NULL_ROW;
    lk_raddr      = cur_r[ID_W-1:0];
    mod_start     = 1'b0;

    // Output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      // Clearing pass after reset
      ST_INIT: begin
        fr_we    = 1'b1;
        fr_waddr = init_r;
        fr_wdata = init_r;
        lk_we    = 1'b1;
        lk_waddr = init_r;
        lk_wdata = NULL_ROW;
        init_nxt = init_r + 1'b1;
        if (init_r == ID_W'(NUM_IDS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        lk_raddr = in_data.target_id;
        if (in_valid) begin
          req_nxt = in_data;
          ev_nxt  = 1'b0;
          res_nxt = '{granted_id: in_data.target_id, default: 1'b0};
          case (in_data.req_type)
            REQ_ALLOC:  st_nxt = ST_A_CHK;
            REQ_FREE:   st_nxt = ST_F_CHK;
            REQ_LOOKUP: st_nxt = ST_L_CHK;
            default:    st_nxt = ST_DONE;
          endcase
        end
      end

      // Allocate: evict if empty, else pick a random free slot; fail if still empty after evicting
      ST_A_CHK: begin
        if (fc_r == '0) begin
          if (!ev_r) begin
            ev_nxt    = 1'b1;
            phase_nxt = 1'b0;
            cnt_nxt   = LINK_W'(EVICT_TAIL_CNT);
            st_nxt    = ST_E_SEG;
          end else begin
            res_nxt = '{granted_id: '0, is_allocated: 1'b0, status: 1'b0, evicted: ev_r};
            st_nxt  = ST_DONE;
          end
        end else begin
          mod_start = 1'b1;
          st_nxt    = ST_A_MOD;
        end
      end

      ST_A_MOD: begin
        fr_raddr = mod_rem;
        if (mod_done) begin
          slot_nxt = mod_rem;
          st_nxt   = ST_A_RDL;
        end
      end

      ST_A_RDL: begin
        x_nxt    = {1'b0, fr_rdata};
        fr_raddr = ID_W'(fc_r - 1'b1);
        st_nxt   = ST_A_WRF;
      end

      // Move the last free entry into the chosen slot
      ST_A_WRF: begin
        fr_we    = 1'b1;
        fr_waddr = slot_r;
        fr_wdata = fr_rdata;
        fc_nxt   = fc_r - 1'b1;
        lk_raddr = head_r[ID_W-1:0];
        st_nxt   = ST_A_WRH;
      end

      ST_A_WRH: begin
        if (head_r != NULL_LINK) begin
          lk_we    = 1'b1;
          lk_waddr = head_r[ID_W-1:0];
          lk_wdata = '{used: rd.used, nxt: rd.nxt, prv: x_r};
        end
        st_nxt = ST_A_WRI;
      end

      // Push the granted identifier at the list head
      ST_A_WRI: begin
        lk_we    = 1'b1;
        lk_waddr = x_r[ID_W-1:0];
        lk_wdata = '{used: 1'b1, nxt: head_r, prv: NULL_LINK};
        head_nxt = x_r;
        if (head_r == NULL_LINK) begin
          tail_nxt = x_r;
        end
        res_nxt = '{granted_id: x_r[ID_W-1:0], is_allocated: 1'b1, status: 1'b0,
                    evicted: ev_r};
        st_nxt  = ST_DONE;
      end

      ST_F_CHK: begin
        if (tid_ok && rd.used) begin
          x_nxt  = {1'b0, req_r.target_id};
          nx_nxt = rd.nxt;
          pv_nxt = rd.prv;
          st_nxt = ST_R1;
        end else begin
          res_nxt.status = 1'b1;
          st_nxt         = ST_DONE;
        end
      end

      ST_L_CHK: begin
        res_nxt.is_allocated = tid_ok && rd.used;
        res_nxt.status       = !(tid_ok && rd.used);
        st_nxt               = ST_DONE;
      end

      // Release: append to free array, clear own row, fix neighbors
      ST_R1: begin
        if (fc_r < LINK_W'(NUM_IDS)) begin
          fr_we    = 1'b1;
          fr_waddr = fc_r[ID_W-1:0];
          fr_wdata = x_r[ID_W-1:0];
          fc_nxt   = fc_r + 1'b1;
        end
        lk_we    = 1'b1;
        lk_waddr = x_r[ID_W-1:0];
        lk_wdata = NULL_ROW;
        lk_raddr = nx_r[ID_W-1:0];
        st_nxt   = ST_R2;
      end

      ST_R2: begin
        if (nx_r != NULL_LINK) begin
          lk_we    = 1'b1;
          lk_waddr = nx_r[ID_W-1:0];
          lk_wdata = '{used: rd.used, nxt: rd.nxt, prv: pv_r};
        end else begin
          tail_nxt = pv_r;
        end
        lk_raddr = pv_r[ID_W-1:0];
        st_nxt   = ST_R3;
      end

      ST_R3: begin
        if (pv_r != NULL_LINK) begin
          lk_we    = 1'b1;
          lk_waddr = pv_r[ID_W-1:0];
          lk_wdata = '{used: rd.used, nxt: nx_r, prv: rd.prv};
        end else begin
          head_nxt = nx_r;
        end
        if (ev_r) begin
          cur_nxt = nx_r;
          cnt_nxt = cnt_r - 1'b1;
          st_nxt  = (cnt_r == LINK_W'(1)) ? ST_E_SEG : ST_E_FRD;
        end else begin
          res_nxt.is_allocated = 1'b1;
          st_nxt               = ST_DONE;
        end
      end

      // Eviction: per run, walk back from the tail, then release forward
      ST_E_SEG: begin
        if (cnt_r == '0) begin
          if (!phase_r) begin
            phase_nxt = 1'b1;
            cnt_nxt   = LINK_W'(EVICT_BODY_CNT);
          end else begin
            st_nxt = ST_A_CHK;
          end
        end else begin
          cur_nxt   = tail_r;
          steps_nxt = cnt_r - 1'b1;
          st_nxt    = (cnt_r == LINK_W'(1)) ? ST_E_FRD : ST_E_WRD;
        end
      end

      ST_E_WRD: begin
        lk_raddr = cur_r[ID_W-1:0];
        st_nxt   = ST_E_WGET;
      end

      ST_E_WGET: begin
        cur_nxt   = rd.prv;
        steps_nxt = steps_r - 1'b1;
        st_nxt    = (steps_r == LINK_W'(1)) ? ST_E_FRD : ST_E_WRD;
      end

      ST_E_FRD: begin
        lk_raddr = cur_r[ID_W-1:0];
        st_nxt   = ST_E_FGET;
      end

      ST_E_FGET: begin
        x_nxt  = cur_r;
        nx_nxt = rd.nxt;
        pv_nxt = rd.prv;
        st_nxt = ST_R1;
      end

      // Hand the result to the output register
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          st_nxt        = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      out_valid_r <= 1'b0;
      fc_r        <= LINK_W'(NUM_IDS);
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      init_r      <= '0;
      ev_r        <= 1'b0;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      steps_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      fc_r        <= fc_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      init_r      <= init_nxt;
      ev_r        <= ev_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      steps_r     <= steps_nxt;
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    x_r        <= x_nxt;
    nx_r       <= nx_nxt;
    pv_r       <= pv_nxt;
    cur_r      <= cur_nxt;
    slot_r     <= slot_nxt;
  end

  // Checks
  a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= LINK_W'(NUM_IDS))
    else $error("free count beyond pool size");

  a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> st_r == ST_A_MOD)
    else $error("modulo finished outside allocate");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_INIT |-> !out_valid_r)
    else $error("result during clearing pass");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> st_r != ST_IDLE)
    else $error("accepted transaction not processed");

endmodule
`default_nettype wire

[tb/sv/rila_checker.sv]
// ----------------------------------------------------------------------------
// rila_checker
// Watches both channels of the identifier allocator, predicts each response
// from its own copy of the free array and recency list, and compares.
// ----------------------------------------------------------------------------
module rila_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire rila_pkg::req_t in_data,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire rila_pkg::rsp_t out_data,
  output int                  errors,
  output int                  pending
);
  import rila_pkg::*;

  localparam int NIL = NUM_IDS;

  // Shadow allocator state
  int   pool[NUM_IDS];
  int   pool_cnt;
  int   nxt[NUM_IDS];
  int   prv[NUM_IDS];
  int   head;
  int   tail;
  bit   busy[NUM_IDS];
  int   age_buf[EVICT_COUNT];
  rsp_t rsp_q[$];

  function automatic void shadow_clear();
    for (int i = 0; i < NUM_IDS; i++) begin
      pool[i] = i;
      nxt[i]  = NIL;
      prv[i]  = NIL;
      busy[i] = 1'b0;
    end
    for (int i = 0; i < EVICT_COUNT; i++) age_buf[i] = 0;
    pool_cnt = NUM_IDS;
    head     = NIL;
    tail     = NIL;
  endfunction

  function automatic void link_front(int id);
    nxt[id] = head;
    prv[id] = NIL;
    if (head != NIL) prv[head] = id;
    else tail = id;
    head = id;
  endfunction

  function automatic void unlink(int id);
    int n;
    int p;
    n = nxt[id];
    p = prv[id];
    if (n < NIL) prv[n] = p;
    else tail = p;
    if (p < NIL) nxt[p] = n;
    else head = n;
    nxt[id] = NIL;
    prv[id] = NIL;
  endfunction

  function automatic void give_back(int id);
    if (pool_cnt < NUM_IDS) begin
      pool[pool_cnt] = id;
      pool_cnt++;
    end
    unlink(id);
    busy[id] = 1'b0;
  endfunction

  // Walk newest to oldest; slots keep the oldest batch, freed in slot order
  function automatic void evict_batch();
    int id;
    int pos;
    int filled;
    id  = head;
    pos = 0;
    while (id < NIL && pos < NUM_IDS) begin
      age_buf[pos % EVICT_COUNT] = id;
      pos++;
      id = nxt[id];
    end
    filled = (pos < EVICT_COUNT) ? pos : EVICT_COUNT;
    for (int i = 0; i < filled; i++)
      if (age_buf[i] < NIL && busy[age_buf[i]]) give_back(age_buf[i]);
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int   tid;
    int   slot;
    int   id;
    tid = r.target_id;
    o.granted_id   = r.target_id;
    o.is_allocated = 1'b0;
    o.status       = 1'b0;
    o.evicted      = 1'b0;
    case (r.req_type)
      REQ_ALLOC: begin
        if (pool_cnt == 0) begin
          evict_batch();
          o.evicted = 1'b1;
        end
        if (pool_cnt == 0) begin
          o.granted_id = '0;
        end else begin
          slot = int'(r.random_value) % pool_cnt;
          id   = pool[slot];
          pool[slot] = pool[pool_cnt - 1];
          pool_cnt--;
          if (id < NIL) begin
            link_front(id);
            busy[id] = 1'b1;
          end
          o.granted_id   = id[9:0];
          o.is_allocated = 1'b1;
        end
      end
      REQ_FREE: begin
        if (tid < NUM_IDS && busy[tid]) begin
          give_back(tid);
          o.is_allocated = 1'b1;
        end else begin
          o.status = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (tid < NUM_IDS && busy[tid]) o.is_allocated = 1'b1;
        else o.status = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    shadow_clear();
  end

  // Predict on each accepted request, compare each accepted response
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst_n) begin
      shadow_clear();
      rsp_q.delete();
    end else begin
      if (in_valid && in_ready) rsp_q.push_back(predict_rsp(in_data));
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected response %h", $time, out_data);
          errors++;
        end else begin
          exp_r = rsp_q.pop_front();
          if (out_data.granted_id !== exp_r.granted_id) begin
            $display("%0t: granted_id expected %0d actual %0d",
                     $time, exp_r.granted_id, out_data.granted_id);
            errors++;
          end
          if (out_data.is_allocated !== exp_r.is_allocated) begin
            $display("%0t: is_allocated expected %0b actual %0b",
                     $time, exp_r.is_allocated, out_data.is_allocated);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $display("%0t: status expected %0b actual %0b",
                     $time, exp_r.status, out_data.status);
            errors++;
          end
          if (out_data.evicted !== exp_r.evicted) begin
            $display("%0t: evicted expected %0b actual %0b",
                     $time, exp_r.evicted, out_data.evicted);
            errors++;
          end
        end
      end
    end
    pending = rsp_q.size();
  end
endmodule

[tb/sv/tb_random_id_allocator_lru_evict.sv]
// ----------------------------------------------------------------------------
// tb_random_id_allocator_lru_evict
// Drives directed and random allocate, free and lookup traffic through the
// allocator, fills the pool to force evictions, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_random_id_allocator_lru_evict;
  import rila_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam int N_RANDOM = 1330;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  int   errors;
  int   pending;

  int   snd_idle;
  int   rcv_idle;
  bit   long_hold;

  random_id_allocator_lru_evict dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rila_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  // Response side backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // One request transaction; called at a falling edge, returns at one
  task automatic send(logic [1:0] kind, logic [9:0] tid, logic [15:0] rnd);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, target_id: tid, random_value: rnd};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [1:0] kind;
    int         roll;
    in_valid  = 1'b0;
    in_data   = '0;
    rst_n     = 1'b0;
    snd_idle  = 25;
    rcv_idle  = 49;
    long_hold = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: first grant at slot zero, then exercise it and the edges
    send(REQ_ALLOC, 10'h3ff, 16'h0000);
    send(REQ_LOOKUP, 10'd0, 16'hffff);
    send(REQ_LOOKUP, 10'd1023, 16'h0000);
    send(REQ_FREE, 10'd0, 16'h0000);
    send(REQ_FREE, 10'd0, 16'hffff);
    send(REQ_LOOKUP, 10'd0, 16'h0000);
    send(REQ_FREE, 10'd1023, 16'h0000);
    send(REQ_BAD, 10'd0, 16'h0000);
    send(REQ_BAD, 10'h3ff, 16'hffff);
    send(REQ_ALLOC, 10'd0, 16'hffff);
    send(REQ_ALLOC, 10'd0, 16'd1022);
    send(REQ_ALLOC, 10'h155, 16'h5555);
    send(REQ_ALLOC, 10'h2aa, 16'haaaa);
    send(REQ_LOOKUP, 10'd1022, 16'h0000);
    send(REQ_FREE, 10'd1022, 16'h0000);

    // Pause until every response has come back
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Random: mostly allocates early so the pool empties and evicts
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        snd_idle = 49;
        rcv_idle = 25;
      end
      if (n == 2 * N_RANDOM / 3) begin
        snd_idle  = 0;
        rcv_idle  = 0;
        long_hold = 1'b1;
      end
      roll = $urandom_range(99);
      if (n < 1150) kind = (roll < 93) ? REQ_ALLOC : (roll < 96) ? REQ_FREE :
                           (roll < 99) ? REQ_LOOKUP : REQ_BAD;
      else kind = (roll < 45) ? REQ_ALLOC : (roll < 75) ? REQ_FREE :
                  (roll < 95) ? REQ_LOOKUP : REQ_BAD;
      send(kind, 10'($urandom), 16'($urandom));
    end
    in_valid <= 1'b0;

    // Drain, then wait for stray responses before the verdict
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
